>>> hdl/rrtt_pkg.sv
// ----------------------------------------------------------------------------
// rrtt_pkg
// Shared types and constants of the round-robin task table: sizes, mode and
// status codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package rrtt_pkg;

    // table geometry
    localparam int NUM_SLOTS    = 16;
    localparam int STACK_STRIDE = 1024;
    localparam int SLOT_W       = $clog2(NUM_SLOTS);
    localparam int CNT_W        = $clog2(NUM_SLOTS + 1);

    // field widths
    localparam int WORD_W = 32;
    localparam int MODE_W = 2;
    localparam int ID_W   = 4;
    localparam int ST_W   = 2;

    // stream and register port widths
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 136;
    localparam int ADDR_W     = 3;

    // register index of stack_top
    localparam logic CFG_STACK_TOP = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD      = 2'd0,
        MODE_EXIT_CUR = 2'd1,
        MODE_EXIT_ID  = 2'd2,
        MODE_SWITCH   = 2'd3
    } mode_t;

    typedef enum logic [ST_W-1:0] {
        ST_UNKNOWN     = 2'd0,
        ST_RUNNING     = 2'd1,
        ST_TERMINATING = 2'd2,
        ST_TERMINATED  = 2'd3
    } task_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MOVE,
        S_MOD,
        S_READ,
        S_DONE
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic op_exec;
        logic sw_save;
        logic sel_last;
        logic sw_remove;
        logic move_wr;
        logic cur_zero;
        logic rem_init;
        logic mod_step;
        logic cur_from_rem;
        logic load_out;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  remove;
        logic  do_move;
        logic  rr_zero;
        logic  mod_done;
        logic  out_free;
    } dp_status_t;

endpackage

>>> hdl/rrtt_ctrl.sv
// ----------------------------------------------------------------------------
// rrtt_ctrl
// Sequencer of the task table: takes one beat, steps the datapath through
// the mode's table accesses and hands the result to the output register.
// ----------------------------------------------------------------------------
module rrtt_ctrl
    import rrtt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.mode != MODE_SWITCH)
                begin
                    state_next = S_DONE;
                end
                else if (status.remove && status.do_move)
                begin
                    state_next = S_MOVE;
                end
                else if (status.remove || status.rr_zero)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_MOD;
                end
            end
            S_MOVE:
            begin
                state_next = S_READ;
            end
            S_MOD:
            begin
                if (status.mod_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            S_EXEC:
            begin
                if (status.mode != MODE_SWITCH)
                begin
                    cmd.op_exec = 1'b1;
                end
                else
                begin
                    cmd.sw_save  = 1'b1;
                    cmd.sel_last = 1'b1;
                    if (status.remove)
                    begin
                        cmd.sw_remove = !status.do_move;
                    end
                    else if (status.rr_zero)
                    begin
                        cmd.cur_zero = 1'b1;
                    end
                    else
                    begin
                        cmd.rem_init = 1'b1;
                    end
                end
            end
            S_MOVE:
            begin
                cmd.move_wr = 1'b1;
            end
            S_MOD:
            begin
                if (status.mod_done)
                begin
                    cmd.cur_from_rem = 1'b1;
                end
                else
                begin
                    cmd.mod_step = 1'b1;
                end
            end
            S_READ:
            begin
                cmd = '0;
            end
            S_DONE:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> hdl/rrtt_datapath.sv
// ----------------------------------------------------------------------------
// rrtt_datapath
// Slot table memories with one write and one registered read port, task
// count and current slot, the round-robin remainder and the result register.
// ----------------------------------------------------------------------------
module rrtt_datapath
    import rrtt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [MODE_W-1:0]     s_tuser,
    input  logic [WORD_W-1:0]     stack_top,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int OUT_USED_W = 1 + ID_W + 4 * WORD_W;

    // latched input beat
    mode_t             mode_reg;
    logic [WORD_W-1:0] entry_pc_reg;
    logic [WORD_W-1:0] slice_len_reg;
    logic [ID_W-1:0]   target_reg;
    logic [WORD_W-1:0] exit_val_reg;
    logic [WORD_W-1:0] halted_pc_reg;
    logic [WORD_W-1:0] halted_sp_reg;

    // table control state
    logic [CNT_W-1:0]     task_count_reg;
    logic [SLOT_W-1:0]    cur_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [NUM_SLOTS-1:0] v_ps_reg;
    logic [NUM_SLOTS-1:0] v_st_reg;

    // slot memories
    logic [WORD_W-1:0] mem_pc    [NUM_SLOTS];
    logic [WORD_W-1:0] mem_sp    [NUM_SLOTS];
    logic [WORD_W-1:0] mem_slice [NUM_SLOTS];
    logic [ST_W-1:0]   mem_st    [NUM_SLOTS];
    logic [WORD_W-1:0] mem_exit  [NUM_SLOTS];

    // registered read port
    logic [WORD_W-1:0] rd_pc_reg;
    logic [WORD_W-1:0] rd_sp_reg;
    logic [WORD_W-1:0] rd_slice_reg;
    logic [ST_W-1:0]   rd_st_reg;
    logic [WORD_W-1:0] rd_exit_reg;
    logic              rd_vps_reg;
    logic              rd_vst_reg;

    // per-beat outcome
    logic              acc_reg;
    logic [WORD_W-1:0] ret_reg;

    // result register
    logic              out_valid_reg;
    logic              out_acc_reg;
    logic [ID_W-1:0]   out_task_reg;
    logic [WORD_W-1:0] out_pc_reg;
    logic [WORD_W-1:0] out_sp_reg;
    logic [WORD_W-1:0] out_slice_reg;
    logic [WORD_W-1:0] out_ret_reg;

    logic [CNT_W-1:0]  last;
    logic [SLOT_W-1:0] last_slot;
    logic [SLOT_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_pc;
    logic [WORD_W-1:0] rd_sp;
    logic [ST_W-1:0]   rd_st;
    logic [WORD_W-1:0] tid_ext;
    logic [SLOT_W-1:0] tid_slot;
    logic              target_ok;
    logic              add_ok;
    logic [WORD_W-1:0] stack_off;
    logic [WORD_W-1:0] new_sp;
    logic              cur_is_zero;
    logic              is_switch;

    logic              we_ps;
    logic              we_slice;
    logic              we_st;
    logic              we_exit;
    logic [SLOT_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_pc;
    logic [WORD_W-1:0] wr_sp;
    logic [WORD_W-1:0] wr_slice;
    logic [ST_W-1:0]   wr_st;
    logic [WORD_W-1:0] wr_exit;

    // derived table values
    assign last        = task_count_reg - CNT_W'(1);
    assign last_slot   = last[SLOT_W-1:0];
    assign rd_addr     = cmd.sel_last ? last_slot : cur_reg;
    assign rd_pc       = rd_vps_reg ? rd_pc_reg : '0;
    assign rd_sp       = rd_vps_reg ? rd_sp_reg : '0;
    assign rd_st       = rd_vst_reg ? rd_st_reg : ST_UNKNOWN;
    assign tid_ext     = WORD_W'(target_reg);
    assign tid_slot    = tid_ext[SLOT_W-1:0];
    assign target_ok   = (target_reg != '0) && (tid_ext < WORD_W'(NUM_SLOTS));
    assign add_ok      = task_count_reg < CNT_W'(NUM_SLOTS);
    assign stack_off   = WORD_W'(task_count_reg) * WORD_W'(STACK_STRIDE);
    assign new_sp      = stack_top - stack_off;
    assign cur_is_zero = (cur_reg == '0);
    assign is_switch   = (mode_reg == MODE_SWITCH);

    // status to the controller
    assign status.mode     = mode_reg;
    assign status.remove   = (rd_st == ST_TERMINATING) && !cur_is_zero;
    assign status.do_move  = (task_count_reg != '0) && (CNT_W'(cur_reg) != last);
    assign status.rr_zero  = (rd_st == ST_TERMINATING) || (task_count_reg <= CNT_W'(1));
    assign status.mod_done = rem_reg < task_count_reg;
    assign status.out_free = !out_valid_reg || m_tready;

    // write port selection
    always_comb
    begin
        we_ps    = 1'b0;
        we_slice = 1'b0;
        we_st    = 1'b0;
        we_exit  = 1'b0;
        wr_addr  = cur_reg;
        wr_pc    = halted_pc_reg;
        wr_sp    = halted_sp_reg;
        wr_slice = rd_slice_reg;
        wr_st    = ST_TERMINATED;
        wr_exit  = '0;
        priority if (cmd.op_exec)
        begin
            unique case (mode_reg)
                MODE_ADD:
                begin
                    we_ps    = add_ok;
                    we_slice = add_ok;
                    we_st    = add_ok;
                    wr_addr  = task_count_reg[SLOT_W-1:0];
                    wr_pc    = entry_pc_reg;
                    wr_sp    = new_sp;
                    wr_slice = slice_len_reg;
                    wr_st    = ST_RUNNING;
                end
                MODE_EXIT_CUR:
                begin
                    we_st   = !cur_is_zero;
                    we_exit = !cur_is_zero;
                    wr_st   = ST_TERMINATING;
                    wr_exit = '0;
                end
                MODE_EXIT_ID:
                begin
                    we_st   = target_ok;
                    we_exit = target_ok;
                    wr_addr = tid_slot;
                    wr_st   = ST_TERMINATING;
                    wr_exit = exit_val_reg;
                end
                MODE_SWITCH:
                begin
                    we_ps = 1'b0;
                end
                default:
                begin
                    we_ps = 1'b0;
                end
            endcase
        end
        else if (cmd.sw_save)
        begin
            // save halted state, retire a terminating task
            we_ps = 1'b1;
            we_st = status.remove;
        end
        else if (cmd.move_wr)
        begin
            // last entry fills the freed slot
            we_ps    = 1'b1;
            we_slice = 1'b1;
            we_st    = 1'b1;
            we_exit  = 1'b1;
            wr_pc    = rd_pc;
            wr_sp    = rd_sp;
            wr_slice = rd_slice_reg;
            wr_st    = rd_st;
            wr_exit  = rd_exit_reg;
        end
        else
        begin
            // no table write this cycle
            we_ps = 1'b0;
        end
    end

    // slot memories, write and registered read
    always_ff @(posedge clk)
    begin
        if (we_ps)
        begin
            mem_pc[wr_addr] <= wr_pc;
            mem_sp[wr_addr] <= wr_sp;
        end
        if (we_slice)
        begin
            mem_slice[wr_addr] <= wr_slice;
        end
        if (we_st)
        begin
            mem_st[wr_addr] <= wr_st;
        end
        if (we_exit)
        begin
            mem_exit[wr_addr] <= wr_exit;
        end
        rd_pc_reg    <= mem_pc[rd_addr];
        rd_sp_reg    <= mem_sp[rd_addr];
        rd_slice_reg <= mem_slice[rd_addr];
        rd_st_reg    <= mem_st[rd_addr];
        rd_exit_reg  <= mem_exit[rd_addr];
    end

    // valid bits of the zero-reset fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_ps_reg   <= '0;
            v_st_reg   <= '0;
            rd_vps_reg <= 1'b0;
            rd_vst_reg <= 1'b0;
        end
        else
        begin
            if (we_ps)
            begin
                v_ps_reg[wr_addr] <= 1'b1;
            end
            if (we_st)
            begin
                v_st_reg[wr_addr] <= 1'b1;
            end
            rd_vps_reg <= v_ps_reg[rd_addr];
            rd_vst_reg <= v_st_reg[rd_addr];
        end
    end

    // input beat capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ADD;
        end
        else if (cmd.load_in)
        begin
            mode_reg <= mode_t'(s_tuser);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            entry_pc_reg  <= s_tdata[31:0];
            slice_len_reg <= s_tdata[63:32];
            target_reg    <= s_tdata[67:64];
            exit_val_reg  <= s_tdata[99:68];
            halted_pc_reg <= s_tdata[131:100];
            halted_sp_reg <= s_tdata[163:132];
        end
    end

    // task count, current slot and round-robin remainder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= '0;
            cur_reg        <= '0;
            rem_reg        <= '0;
        end
        else
        begin
            if (cmd.op_exec && (mode_reg == MODE_ADD) && add_ok)
            begin
                task_count_reg <= task_count_reg + CNT_W'(1);
            end
            if (cmd.sw_remove && (task_count_reg != '0))
            begin
                task_count_reg <= last;
            end
            if (cmd.move_wr)
            begin
                task_count_reg <= last;
            end
            if (cmd.sw_remove || cmd.move_wr || cmd.cur_zero)
            begin
                cur_reg <= '0;
            end
            if (cmd.cur_from_rem)
            begin
                cur_reg <= rem_reg[SLOT_W-1:0];
            end
            if (cmd.rem_init)
            begin
                rem_reg <= CNT_W'(cur_reg) + CNT_W'(1);
            end
            if (cmd.mod_step)
            begin
                rem_reg <= rem_reg - task_count_reg;
            end
        end
    end

    // outcome of the beat
    always_ff @(posedge clk)
    begin
        if (cmd.op_exec)
        begin
            unique case (mode_reg)
                MODE_ADD:      acc_reg <= add_ok;
                MODE_EXIT_CUR: acc_reg <= !cur_is_zero;
                MODE_EXIT_ID:  acc_reg <= target_ok;
                MODE_SWITCH:   acc_reg <= 1'b1;
                default:       acc_reg <= 1'b0;
            endcase
            ret_reg <= ((mode_reg == MODE_EXIT_ID) && target_ok) ? exit_val_reg : '0;
        end
        else if (cmd.sw_save)
        begin
            acc_reg <= 1'b1;
            ret_reg <= '0;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_acc_reg   <= acc_reg;
            out_task_reg  <= ID_W'(cur_reg);
            out_pc_reg    <= is_switch ? rd_pc : '0;
            out_sp_reg    <= is_switch ? rd_sp : '0;
            out_slice_reg <= is_switch ? rd_slice_reg : '0;
            out_ret_reg   <= ret_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, out_ret_reg, out_slice_reg,
                       out_sp_reg, out_pc_reg, out_task_reg, out_acc_reg};

endmodule

>>> hdl/round_robin_task_table.sv
// ----------------------------------------------------------------------------
// round_robin_task_table
// Hardware task table with round-robin switching: add, exit and switch
// operations on a slot table, with the stack_top register on an APB port.
//
//   channel   dir   beat fields
//   s_*       in    tuser: mode; tdata: entry_pc, slice_length, target_id,
//                   exit_value, halted_pc, halted_sp
//   m_*       out   tdata: accepted, next_task, next_pc, next_sp,
//                   next_slice, return_reg
//   apb       in    register 0 at byte address 0: stack_top
//
// Add and exit beats go from accept through the exec and done states to the
// result register; a switch back to task 0 passes a read state as well, a removal
// that moves the last entry into the freed slot adds a move state before the read,
// and a round-robin step adds the modulo state, repeated when the step wraps.
// Reset clears count, current slot and valid bits at once; no clearing pass.
// A stalled result waits in the output register; a new beat is taken while
// it waits, and the sequencer holds before loading the next result.
// ----------------------------------------------------------------------------
module round_robin_task_table
    import rrtt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // stream input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [31:0] entry_pc, [63:32] slice_length, [67:64] target_id,
    // [99:68] exit_value, [131:100] halted_pc, [163:132] halted_sp, rest zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  logic [MODE_W-1:0]     s_tuser,
    // stream output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] accepted, [4:1] next_task, [36:5] next_pc, [68:37] next_sp,
    // [100:69] next_slice, [132:101] return_reg, rest zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [WORD_W-1:0]     pwdata,
    output logic [WORD_W-1:0]     prdata,
    output logic                  pready
);

    logic [WORD_W-1:0] stack_top_reg;
    logic              cfg_wr;
    logic              cfg_hit;
    dp_cmd_t           cmd;
    dp_status_t        status;

    // register write and read back
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == CFG_STACK_TOP);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = cfg_hit ? stack_top_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_top_reg <= '0;
        end
        else if (cfg_wr && cfg_hit)
        begin
            stack_top_reg <= pwdata;
        end
    end

    // sequencer
    rrtt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // table and result datapath
    rrtt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .stack_top (stack_top_reg),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> tb/round_robin_task_table_checker.sv
// ----------------------------------------------------------------------------
// round_robin_task_table_checker
// Watches the stream and register ports of the task table, keeps its own copy
// of the slot table, works out the result of every accepted command beat and
// compares each result beat against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module round_robin_task_table_checker
    import rrtt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [MODE_W-1:0]     s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [WORD_W-1:0]     pwdata,
    input  logic [WORD_W-1:0]     prdata,
    input  logic                  pready,
    output int                    errors,
    output int                    pending,
    output int                    checked,
    output int                    refused,
    output int                    removals
);

    localparam logic [ADDR_W-1:0] STACK_TOP_ADDR = ADDR_W'(CFG_STACK_TOP) << 2;

    // command beat payload, first field in the low bits
    typedef struct packed {
        logic [WORD_W-1:0] halted_sp;
        logic [WORD_W-1:0] halted_pc;
        logic [WORD_W-1:0] exit_value;
        logic [ID_W-1:0]   target_id;
        logic [WORD_W-1:0] slice_length;
        logic [WORD_W-1:0] entry_pc;
    } sched_cmd_t;

    // result beat payload, first field in the low bits
    typedef struct packed {
        logic [WORD_W-1:0] return_reg;
        logic [WORD_W-1:0] next_slice;
        logic [WORD_W-1:0] next_sp;
        logic [WORD_W-1:0] next_pc;
        logic [ID_W-1:0]   next_task;
        logic              accepted;
    } sched_result_t;

    // shadow slot table
    logic [WORD_W-1:0] tbl_pc    [NUM_SLOTS];
    logic [WORD_W-1:0] tbl_sp    [NUM_SLOTS];
    logic [WORD_W-1:0] tbl_slice [NUM_SLOTS];
    logic [WORD_W-1:0] tbl_code  [NUM_SLOTS];
    task_status_t      tbl_state [NUM_SLOTS];
    int                live_count;
    int                cur_slot;
    logic [WORD_W-1:0] stack_base;

    sched_result_t expected_results[$];

    // apply one command to the shadow table and return the result it gives
    function automatic sched_result_t run_command(mode_t op, sched_cmd_t c);
        sched_result_t r;
        int cur;
        int last;
        r   = '0;
        cur = cur_slot;
        case (op)
            MODE_ADD:
                if (live_count < NUM_SLOTS) begin
                    tbl_pc[live_count]    = c.entry_pc;
                    tbl_sp[live_count]    = stack_base - WORD_W'(live_count * STACK_STRIDE);
                    tbl_slice[live_count] = c.slice_length;
                    tbl_state[live_count] = ST_RUNNING;
                    live_count++;
                    r.accepted = 1'b1;
                end
            MODE_EXIT_CUR:
                if (cur != 0) begin
                    tbl_state[cur] = ST_TERMINATING;
                    tbl_code[cur]  = '0;
                    r.accepted     = 1'b1;
                end
            MODE_EXIT_ID:
                if (c.target_id != 0 && int'(c.target_id) < NUM_SLOTS) begin
                    tbl_state[c.target_id] = ST_TERMINATING;
                    tbl_code[c.target_id]  = c.exit_value;
                    r.return_reg           = c.exit_value;
                    r.accepted             = 1'b1;
                end
            default:
            begin
                tbl_pc[cur] = c.halted_pc;
                tbl_sp[cur] = c.halted_sp;
                if (tbl_state[cur] == ST_TERMINATING) begin
                    // retire the task: last entry fills the hole, back to task 0
                    if (cur != 0) begin
                        tbl_state[cur] = ST_TERMINATED;
                        removals++;
                        if (live_count > 0) begin
                            last = live_count - 1;
                            if (cur != last) begin
                                tbl_pc[cur]    = tbl_pc[last];
                                tbl_sp[cur]    = tbl_sp[last];
                                tbl_slice[cur] = tbl_slice[last];
                                tbl_state[cur] = tbl_state[last];
                                tbl_code[cur]  = tbl_code[last];
                            end
                            live_count = last;
                        end
                        cur = 0;
                    end
                end else begin
                    cur = (live_count <= 1) ? 0 : (cur + 1) % live_count;
                end
                cur_slot     = cur;
                r.next_pc    = tbl_pc[cur];
                r.next_sp    = tbl_sp[cur];
                r.next_slice = tbl_slice[cur];
                r.accepted   = 1'b1;
            end
        endcase
        r.next_task = ID_W'(cur_slot);
        return r;
    endfunction

    task automatic check_field(input string what, input logic [WORD_W-1:0] want_v,
                               input logic [WORD_W-1:0] got_v);
        if (want_v !== got_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
        end
    endtask

    // sample both channels and the register port at every rising edge
    always @(posedge clk) begin
        sched_result_t want;
        sched_result_t got;
        if (!rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                tbl_pc[i]    = '0;
                tbl_sp[i]    = '0;
                tbl_slice[i] = '0;
                tbl_code[i]  = '0;
                tbl_state[i] = ST_UNKNOWN;
            end
            live_count = 0;
            cur_slot   = 0;
            stack_base = '0;
            errors     = 0;
            checked    = 0;
            refused    = 0;
            removals   = 0;
            expected_results.delete();
        end else begin
            // result beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                got = sched_result_t'(m_tdata[$bits(sched_result_t)-1:0]);
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected, actual %h",
                             $time, got);
                end else begin
                    want = expected_results.pop_front();
                    check_field("accepted", WORD_W'(want.accepted), WORD_W'(got.accepted));
                    check_field("next_task", WORD_W'(want.next_task), WORD_W'(got.next_task));
                    check_field("next_pc", want.next_pc, got.next_pc);
                    check_field("next_sp", want.next_sp, got.next_sp);
                    check_field("next_slice", want.next_slice, got.next_slice);
                    check_field("return_reg", want.return_reg, got.return_reg);
                    checked++;
                end
            end
            // command beat feeds the prediction
            if (s_tvalid && s_tready) begin
                want = run_command(mode_t'(s_tuser),
                                   sched_cmd_t'(s_tdata[$bits(sched_cmd_t)-1:0]));
                if (!want.accepted)
                    refused++;
                expected_results.push_back(want);
            end
            // register writes and read-back
            if (psel && penable && pready && paddr == STACK_TOP_ADDR) begin
                if (pwrite) begin
                    stack_base = pwdata;
                end else if (prdata !== stack_base) begin
                    errors++;
                    $display("%0t: stack_top read mismatch, expected %h, actual %h",
                             $time, stack_base, prdata);
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

>>> tb/tb_round_robin_task_table.sv
// ----------------------------------------------------------------------------
// tb_round_robin_task_table
// Drives the task table with a directed opening (refused exits of task 0, a
// full table, removal with a slot move, exit of an id past the count) and
// then random add/exit/switch traffic in grow and shrink phases under several
// stack_top settings, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_round_robin_task_table;
    import rrtt_pkg::*;

    localparam logic [ADDR_W-1:0] STACK_TOP_ADDR = ADDR_W'(CFG_STACK_TOP) << 2;
    localparam int PHASE_BEATS = 112;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // [31:0] entry_pc, [63:32] slice_length, [67:64] target_id,
    // [99:68] exit_value, [131:100] halted_pc, [163:132] halted_sp
    logic [IN_DATA_W-1:0]  s_tdata;
    // [1:0] mode
    logic [MODE_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] accepted, [4:1] next_task, [36:5] next_pc, [68:37] next_sp,
    // [100:69] next_slice, [132:101] return_reg
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [WORD_W-1:0]     pwdata;
    logic [WORD_W-1:0]     prdata;
    logic                  pready;

    int errors;
    int pending;
    int checked;
    int refused;
    int removals;

    int burst_left  = 0;
    int beats_sent  = 0;
    int mode_beats[4] = '{0, 0, 0, 0};
    bit slot0_ready = 1'b0;

    round_robin_task_table DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    round_robin_task_table_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .errors(errors), .pending(pending), .checked(checked),
        .refused(refused), .removals(removals)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("tb_round_robin_task_table: done, errors");
        $finish;
    end

    // output side stall pattern, in random styles that switch when a random countdown runs out
    int ready_style = 0;
    int style_left  = 0;
    always @(negedge clk) begin
        if (style_left == 0) begin
            ready_style = $urandom_range(0, 3);
            style_left  = $urandom_range(40, 200);
        end
        style_left--;
        case (ready_style)
            0:       m_tready = 1'b1;
            1:       m_tready = ($urandom_range(0, 9) < 7);
            2:       m_tready = ($urandom_range(0, 9) < 2);
            default: m_tready = ((style_left % 32) >= 20);
        endcase
    end

    // mostly random words, with the extremes now and then
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // one register cycle: setup then access, called at a falling edge
    task automatic reg_access(input bit wr, input logic [WORD_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = STACK_TOP_ADDR;
        pwdata  = wr ? value : '0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // one command beat, with bursts and random gaps between them
    task automatic send_beat(input mode_t op, input logic [WORD_W-1:0] entry_pc,
                             input logic [WORD_W-1:0] slice_length,
                             input logic [ID_W-1:0] target_id,
                             input logic [WORD_W-1:0] exit_value,
                             input logic [WORD_W-1:0] halted_pc,
                             input logic [WORD_W-1:0] halted_sp);
        int gap;
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = IN_DATA_W'({halted_sp, halted_pc, exit_value, target_id,
                               slice_length, entry_pc});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        burst_left--;
        beats_sent++;
        mode_beats[op]++;
        if (op == MODE_ADD)
            slot0_ready = 1'b1;
    endtask

    task automatic send_random(input mode_t op);
        send_beat(op, rand_word(), rand_word(), ID_W'($urandom_range(0, 15)),
                  rand_word(), rand_word(), rand_word());
    endtask

    // weighted pick; an exit of the current task is often followed by a switch
    task automatic random_beat(input bit grow);
        int    pick;
        mode_t op;
        pick = $urandom_range(0, 99);
        if (pick < (grow ? 40 : 10))
            op = MODE_ADD;
        else if (pick < (grow ? 50 : 35))
            op = MODE_EXIT_CUR;
        else if (pick < (grow ? 65 : 50))
            op = MODE_EXIT_ID;
        else
            op = MODE_SWITCH;
        // slot 0 has no slice until the first add
        if (op == MODE_SWITCH && !slot0_ready)
            op = MODE_ADD;
        send_random(op);
        if (op == MODE_EXIT_CUR && $urandom_range(0, 9) < 6)
            send_random(MODE_SWITCH);
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain();
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    logic [WORD_W-1:0] top_values[4];
    int phase_start;
    bit mid_drained;
    int wait_cycles;

    initial begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_ADD;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        top_values = '{32'h0000_0000, $urandom, 32'h8000_0000, $urandom};

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        reg_access(1'b1, 32'hFFFF_FFFF);
        reg_access(1'b0, '0);

        // directed opening: task 0 cannot exit
        send_random(MODE_EXIT_CUR);
        send_beat(MODE_EXIT_ID, rand_word(), rand_word(), '0, rand_word(),
                  rand_word(), rand_word());
        // fill the table, smallest and largest fields first, then one too many
        send_beat(MODE_ADD, '0, '0, '0, '0, '0, '0);
        send_beat(MODE_ADD, '1, '1, '1, '1, '1, '1);
        for (int i = 2; i < NUM_SLOTS; i++)
            send_random(MODE_ADD);
        send_random(MODE_ADD);
        // move to task 1, exit it, switch: last entry moves into its slot
        send_beat(MODE_SWITCH, rand_word(), rand_word(), '0, rand_word(), '1, '1);
        send_random(MODE_EXIT_CUR);
        send_beat(MODE_SWITCH, rand_word(), rand_word(), '0, rand_word(), '0, '0);
        send_random(MODE_SWITCH);
        // slot 15 now lies past the count but still within the table
        send_beat(MODE_EXIT_ID, rand_word(), rand_word(), 4'd15, '1,
                  rand_word(), rand_word());

        // random phases, alternating growth and shrinkage of the table
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            reg_access(1'b1, top_values[ph]);
            reg_access(1'b0, '0);
            phase_start = beats_sent;
            mid_drained = 1'b0;
            while (beats_sent - phase_start < PHASE_BEATS) begin
                if (!mid_drained && beats_sent - phase_start >= PHASE_BEATS / 2) begin
                    drain();
                    mid_drained = 1'b1;
                end
                random_beat(ph % 2 == 0);
            end
        end

        s_tvalid    = 1'b0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (20) @(negedge clk);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);

        $display("covered %0d beats: %0d add, %0d exit current, %0d exit by id, %0d switch",
                 beats_sent, mode_beats[MODE_ADD], mode_beats[MODE_EXIT_CUR],
                 mode_beats[MODE_EXIT_ID], mode_beats[MODE_SWITCH]);
        $display("%0d results compared, %0d refused operations, %0d tasks retired",
                 checked, refused, removals);
        if (errors == 0 && pending == 0)
            $display("tb_round_robin_task_table: done, clean");
        else
            $display("tb_round_robin_task_table: done, errors");
        $finish;
    end

endmodule
